// ===== sv/wbcs_pkg.sv =====
// Shared types and constants for the white blob centroid steering block.
// Used by every module of the block; depends on nothing.
package wbcs_pkg;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 12;
	localparam int SUM_W      = 33;
	localparam int COUNT_W    = 23;
	localparam int MEAN_W     = 11;
	localparam int WIDTH_W    = 14;   // effective width, up to 4095
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam int                MAX_WIDTH_DEFAULT = 2048;
	localparam logic [CFG_W-1:0]  WIDTH_RESET       = 12'd640;
	localparam logic [PIX_W-1:0]  WHITE_LEVEL       = 8'hFF;
	localparam logic [SUM_W-1:0]  SUM_MAX           = {SUM_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

	// floor(x/3) = (x * 43691) >> 17, exact for x below 2^16
	localparam int DIV3_MUL   = 43691;
	localparam int DIV3_SHIFT = 17;

	// Frame queue
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_STOP    = 2'd0,
		CMD_FORWARD = 2'd1,
		CMD_LEFT    = 2'd2,
		CMD_RIGHT   = 2'd3
	} steer_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

	// Totals of one finished frame, handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
		logic [WIDTH_W-1:0] width;
	} frame_totals_t;

endpackage

// ===== sv/wbcs_front.sv =====
// Front end: takes pixels, classifies white ones, accumulates column sum and count.
// Pushes one frame_totals_t per frame into the queue. Depends on wbcs_pkg.
module wbcs_front import wbcs_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CFG_W-1:0]     image_width,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  logic [PIX_W-1:0]     red,
	input  logic [PIX_W-1:0]     green,
	input  logic [PIX_W-1:0]     blue,
	input  logic                 frame_end,
	input  logic                 queue_full,
	output logic                 push,
	output frame_totals_t        push_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [COL_W-1:0]   column_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic               white;
	logic [WIDTH_W-1:0] eff_width;
	logic [SUM_W:0]     sum_add;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] count_next;
	logic [WIDTH_W-1:0] column_inc;

	assign pix_ready = !queue_full;
	assign accept    = pix_valid && pix_ready;
	assign white     = (red == WHITE_LEVEL) && (green == WHITE_LEVEL) && (blue == WHITE_LEVEL);

	// Clamp the configured width to 1..MAX_WIDTH
	always_comb begin
		if (image_width == '0) begin
			eff_width = WIDTH_W'(1);
		end else if ({{(WIDTH_W-CFG_W){1'b0}}, image_width} > WIDTH_W'(MAX_WIDTH)) begin
			eff_width = WIDTH_W'(MAX_WIDTH);
		end else begin
			eff_width = {{(WIDTH_W-CFG_W){1'b0}}, image_width};
		end
	end

	// Saturating accumulate of the current pixel
	always_comb begin
		sum_add    = {1'b0, sum_q} + (SUM_W+1)'(column_q);
		sum_next   = sum_q;
		count_next = count_q;
		if (white) begin
			sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
			count_next = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
		end
		column_inc = WIDTH_W'(column_q) + 1'b1;
	end

	assign push            = accept && frame_end;
	assign push_data.sum   = sum_next;
	assign push_data.count = count_next;
	assign push_data.width = eff_width;

	// Accumulators and column counter; cleared after the frame's last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			sum_q    <= '0;
			count_q  <= '0;
		end else if (accept) begin
			if (frame_end) begin
				column_q <= '0;
				sum_q    <= '0;
				count_q  <= '0;
			end else begin
				column_q <= (column_inc >= eff_width) ? '0 : column_inc[COL_W-1:0];
				sum_q    <= sum_next;
				count_q  <= count_next;
			end
		end
	end

endmodule

// ===== sv/wbcs_queue.sv =====
// Short queue of frame totals between front and back end.
// Depends on wbcs_pkg for frame_totals_t.
module wbcs_queue import wbcs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  frame_totals_t push_data,
	input  logic          pop,
	output frame_totals_t pop_data,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_totals_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/wbcs_back.sv =====
// Back end: divides column sum by white count one quotient bit per cycle,
// picks the steering command and holds it in the output register. Depends on wbcs_pkg.
module wbcs_back import wbcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  queue_empty,
	input  frame_totals_t         queue_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	back_state_t        state_q, state_next;
	logic [SUM_W-1:0]   quo_q;      // dividend shifting out, quotient shifting in
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] den_q;
	logic [WIDTH_W-1:0] left_q;
	logic [WIDTH_W-1:0] right_q;
	logic [STEP_W-1:0]  step_q;

	logic               out_valid_q;
	steer_cmd_t         cmd_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [COUNT_W-1:0] total_q;

	logic               load;
	logic               step;
	logic               finish;
	logic               slot_free;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   trial_sub;
	logic [31:0]        left_prod;
	logic [31:0]        right_prod;
	steer_cmd_t         cmd_new;

	assign slot_free = !out_valid_q || out_ready;

	// Control sequence
	always_comb begin
		state_next = state_q;
		load       = 1'b0;
		step       = 1'b0;
		finish     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!queue_empty) begin
					load       = 1'b1;
					state_next = (queue_data.count == '0) ? BK_FIN : BK_DIV;
				end
			end
			BK_DIV: begin
				step = 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_next = BK_FIN;
				end
			end
			BK_FIN: begin
				if (slot_free) begin
					finish     = 1'b1;
					state_next = BK_IDLE;
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Boundaries width/3 and 2*width/3 by reciprocal multiply
	assign left_prod  = 32'(queue_data.width) * 32'(DIV3_MUL);
	assign right_prod = {17'd0, queue_data.width, 1'b0} * 32'(DIV3_MUL);

	// One restoring division step
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};

	// Divider datapath
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q   <= queue_data.sum;
			rem_q   <= '0;
			den_q   <= queue_data.count;
			left_q  <= WIDTH_W'(left_prod >> DIV3_SHIFT);
			right_q <= WIDTH_W'(right_prod >> DIV3_SHIFT);
			step_q  <= '0;
		end else if (step) begin
			if (!trial_sub[COUNT_W]) begin
				rem_q <= trial_sub[COUNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[COUNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
			step_q <= step_q + 1'b1;
		end
	end

	// Command from the mean, stop when no pixel was white; a mean on a boundary goes forward
	always_comb begin
		if (den_q == '0) begin
			cmd_new = CMD_STOP;
		end else if (quo_q > SUM_W'(right_q)) begin
			cmd_new = CMD_RIGHT;
		end else if (quo_q < SUM_W'(left_q)) begin
			cmd_new = CMD_LEFT;
		end else begin
			cmd_new = CMD_FORWARD;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			cmd_q   <= cmd_new;
			mean_q  <= (den_q == '0) ? '0 : quo_q[MEAN_W-1:0];
			total_q <= den_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {
		(OUT_DATA_W - COUNT_W - MEAN_W - 2)'(0), total_q, mean_q, cmd_q
	};

endmodule

// ===== sv/white_blob_centroid_steer_top.sv =====
// Top level of the white blob centroid steering block.
// Instantiates wbcs_front, wbcs_queue and wbcs_back; depends on wbcs_pkg.
//
// Usage:
//  - Pixels enter on the s_axis channel in raster order, one transfer per pixel,
//    s_axis_tlast on the last pixel of a frame. A pixel is white when red, green
//    and blue are all 255.
//  - One result leaves on the m_axis channel per frame: steering command, truncated
//    mean column of the white pixels and the white pixel count.
//  - cfg_wr_en/cfg_wr_data set the row width (1..MAX_WIDTH after clamping);
//    write it only while no frame is in flight.
//  - Throughput: one pixel per cycle while the frame queue has room.
//  - From the last pixel's transfer to m_axis_tvalid, a frame with white pixels
//    passes the queue, a load, 33 one-bit steps of the sum/count divider and the
//    output write; a frame with none skips the divider steps. The divider serves one
//    frame at a time; a two-entry queue of frame totals sits in front of it.
//  - When the receiver stalls, the result waits in the output register, the
//    divider finishes the next frame and waits, and the queue fills; once it
//    is full s_axis_tready drops.
//  - Reset clears the accumulators, column counter, queue and output valid and
//    sets the width to 640.
module white_blob_centroid_steer_top import wbcs_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,    // image_width
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic                  s_axis_tlast,   // frame_end
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // steer_command[1:0], mean_column[12:2],
	                                              // white_total[35:13], zero[39:36]
);

	logic [CFG_W-1:0] image_width_q;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;
	frame_totals_t    push_data;
	frame_totals_t    pop_data;

	// Width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			image_width_q <= cfg_wr_data;
		end
	end

	wbcs_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (image_width_q),
		.pix_valid   (s_axis_tvalid),
		.pix_ready   (s_axis_tready),
		.red         (s_axis_tdata[7:0]),
		.green       (s_axis_tdata[15:8]),
		.blue        (s_axis_tdata[23:16]),
		.frame_end   (s_axis_tlast),
		.queue_full  (queue_full),
		.push        (push),
		.push_data   (push_data)
	);

	wbcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	wbcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.queue_data  (pop_data),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

`ifndef SYNTHESIS
	// A frame is stop exactly when it had no white pixel
	a_stop_iff_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			((m_axis_tdata[35:13] == '0) == (m_axis_tdata[1:0] == CMD_STOP)))
		else $error("stop command does not match white count");

	// Stop frames report a zero mean
	a_stop_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[1:0] == CMD_STOP)) |-> (m_axis_tdata[12:2] == '0))
		else $error("stop result with nonzero mean");

	// The back end never takes totals from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("frame queue popped while empty");
`endif

endmodule
